// ===== rtl/edad_pkg.sv =====
package edad_pkg;

  localparam int unsigned PosWidth   = 14;
  localparam int unsigned CountWidth = 12;
  localparam logic [PosWidth-1:0] PosMax = '1;
  localparam logic [3:0] CheckTarget = 4'hF;
  localparam logic [7:0] SeedReset   = 8'hA9;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StPadding = 3'd1,
    StSize    = 3'd2,
    StNibble  = 3'd3,
    StLength  = 3'd4,
    StParity  = 3'd5
  } edad_status_e;

  typedef struct packed {
    logic [7:0] area_byte;
    logic       is_last;
  } edad_item_t;

  typedef struct packed {
    logic [7:0]   payload_byte;
    logic         payload_valid;
    logic         area_done;
    edad_status_e status;
  } edad_result_t;

endpackage

// ===== rtl/edad_in_reg.sv =====
module edad_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  edad_pkg::edad_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output edad_pkg::edad_item_t item_o
);
  import edad_pkg::*;

  logic       valid_q, valid_d;
  edad_item_t item_q;
  logic       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/edad_core.sv =====
module edad_core #(
  parameter int unsigned MAX_AREA_WORDS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   seed_we_i,
  input  logic [7:0]             seed_i,
  input  logic                   advance_i,
  input  edad_pkg::edad_item_t   item_i,
  output edad_pkg::edad_result_t result_o
);
  import edad_pkg::*;

  localparam logic [CountWidth:0] MaxWords = (CountWidth + 1)'(MAX_AREA_WORDS);

  logic [7:0]            seed_q;
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [7:0]            hdr_hi_q, hdr_hi_d;
  logic [CountWidth-1:0] wcf_q, wcf_d;
  logic [7:0]            acc_q, acc_d;
  logic                  good_q, good_d;
  logic                  pad_q, pad_d;

  logic                  is_p0, is_p1;
  logic [3:0]            chk;
  logic [CountWidth-1:0] wcf_new, wcf_eff;
  logic                  good_new, good_eff, pad_new, pad_eff;
  logic [7:0]            acc_eff;
  logic [CountWidth:0]   words;
  logic [CountWidth+1:0] total;
  logic [PosWidth:0]     n;
  logic                  size_bad, length_bad;
  logic [7:0]            b;

  assign b       = item_i.area_byte;
  assign is_p0   = (pos_q == '0);
  assign is_p1   = (pos_q == PosWidth'(1));
  assign chk     = hdr_hi_q[7:4] ^ hdr_hi_q[3:0] ^ b[7:4] ^ b[3:0];
  assign wcf_new = {hdr_hi_q[3:0], b};
  assign good_new = (chk == CheckTarget);
  assign pad_new  = (hdr_hi_q == 8'd0) && (b == 8'd0);

  // The second header byte settles the header fields in the same cycle.
  assign wcf_eff  = is_p1 ? wcf_new  : wcf_q;
  assign good_eff = is_p1 ? good_new : good_q;
  assign pad_eff  = is_p1 ? pad_new  : pad_q;
  assign acc_eff  = is_p1 ? seed_q   : acc_q;

  assign words = {1'b0, wcf_eff} + (CountWidth + 1)'(1);
  assign total = {words, 1'b0};
  assign n     = {1'b0, pos_q} + (PosWidth + 1)'(1);

  assign size_bad   = (pos_q == PosMax) || !pos_q[0];
  assign length_bad = (total != (CountWidth + 2)'(n)) || (n > (PosWidth + 1)'(total))
                   || (wcf_eff == '0) || (words > MaxWords);

  always_comb begin
    result_o = '0;
    result_o.status = StOk;
    if (!is_p0 && !is_p1 && !item_i.is_last) begin
      result_o.payload_valid = 1'b1;
      result_o.payload_byte  = b;
    end
    if (item_i.is_last) begin
      result_o.area_done = 1'b1;
      if (size_bad) begin
        result_o.status = StSize;
      end else if (pad_eff) begin
        result_o.status = StPadding;
      end else if (!good_eff) begin
        result_o.status = StNibble;
      end else if (length_bad) begin
        result_o.status = StLength;
      end else if (acc_eff != b) begin
        result_o.status = StParity;
      end else begin
        result_o.status = StOk;
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    hdr_hi_d = hdr_hi_q;
    wcf_d    = wcf_q;
    acc_d    = acc_q;
    good_d   = good_q;
    pad_d    = pad_q;
    if (advance_i) begin
      if (item_i.is_last) begin
        pos_d    = '0;
        hdr_hi_d = '0;
        wcf_d    = '0;
        acc_d    = seed_q;
        good_d   = 1'b0;
        pad_d    = 1'b0;
      end else begin
        if (is_p0) begin
          hdr_hi_d = b;
        end else if (is_p1) begin
          wcf_d  = wcf_new;
          good_d = good_new;
          pad_d  = pad_new;
          acc_d  = seed_q;
        end else begin
          acc_d = acc_q ^ b;
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + PosWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= SeedReset;
      pos_q    <= '0;
      hdr_hi_q <= '0;
      wcf_q    <= '0;
      acc_q    <= SeedReset;
      good_q   <= 1'b0;
      pad_q    <= 1'b0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      pos_q    <= pos_d;
      hdr_hi_q <= hdr_hi_d;
      wcf_q    <= wcf_d;
      acc_q    <= acc_d;
      good_q   <= good_d;
      pad_q    <= pad_d;
    end
  end

endmodule

// ===== rtl/extra_data_area_deframer.sv =====
// A transaction accepted into the input register is offered on the outputs once it has passed into the result register.
// Throughput: one byte per cycle; an output stall holds the result register and then the input register.
// The input register takes a new byte while a finished result waits to be taken.
// Reset clears all area state, loads the parity seed with 0xA9, and empties both
// registers; no clearing pass is needed after reset.
module extra_data_area_deframer #(
  parameter int unsigned MAX_AREA_WORDS = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       parity_seed_we_i,
  input  logic [7:0] parity_seed_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] area_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       area_done_o,
  output logic [2:0] status_o
);
  import edad_pkg::*;

  edad_item_t   item_in, item_s1;
  edad_result_t result, result_q;
  logic         s1_valid, advance;
  logic         out_valid_q, out_valid_d;

  assign item_in.area_byte = area_byte_i;
  assign item_in.is_last   = is_last_i;

  assign advance = s1_valid && (!out_valid_q || out_ready_i);

  edad_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (item_s1)
  );

  edad_core #(
    .MAX_AREA_WORDS (MAX_AREA_WORDS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (parity_seed_we_i),
    .seed_i    (parity_seed_i),
    .advance_i (advance),
    .item_i    (item_s1),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = result_q.payload_byte;
  assign payload_valid_o = result_q.payload_valid;
  assign area_done_o     = result_q.area_done;
  assign status_o        = result_q.status;

  a_done_no_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && area_done_o |-> !payload_valid_o)
    else $error("Final byte of an area was marked as payload.");

  a_status_only_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !area_done_o |-> status_o == StOk)
    else $error("Status reported on a transaction that does not end an area.");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid && out_valid_q && !out_ready_i)
    else $error("Input stalled without a full pipeline.");

endmodule

// ===== sim/extra_data_area_deframer_tb.sv =====
`timescale 1ns / 1ps

module extra_data_area_deframer_tb;
  import edad_pkg::*;

  localparam int unsigned MaxAreaWords = 4096;
  localparam int unsigned RandomItems = 580;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic seed_we = 1'b0;
  logic [7:0] seed_data = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] area_byte = 8'h00;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic payload_valid;
  logic area_done;
  logic [2:0] status;

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned outputs_checked = 0;
  int unsigned seed_writes = 0;
  int unsigned mismatches = 0;
  int unsigned areas_by_status [6];

  // Shadow copy of the deframer state.
  logic [PosWidth-1:0] sh_pos = '0;
  logic [7:0] sh_high = '0;
  logic [CountWidth-1:0] sh_count = '0;
  logic [7:0] sh_parity = SeedReset;
  logic sh_header_ok = 1'b0;
  logic sh_padding = 1'b0;
  logic [7:0] sh_seed = SeedReset;

  edad_result_t deframer_outputs [$];

  extra_data_area_deframer #(
    .MAX_AREA_WORDS(MaxAreaWords)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .parity_seed_we_i(seed_we),
    .parity_seed_i   (seed_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .area_byte_i     (area_byte),
    .is_last_i       (is_last),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .area_done_o     (area_done),
    .status_o        (status)
  );

  always #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    edad_result_t r;
    int unsigned n;
    int unsigned words;
    logic [3:0] chk;
    r = '0;
    if (sh_pos == 0) begin
      sh_high = b;
    end else if (sh_pos == 1) begin
      chk = sh_high[7:4] ^ sh_high[3:0] ^ b[7:4] ^ b[3:0];
      sh_count = {sh_high[3:0], b};
      sh_header_ok = (chk == CheckTarget);
      sh_padding = (sh_high == 8'h00) && (b == 8'h00);
      sh_parity = sh_seed;
    end else if (!last) begin
      sh_parity = sh_parity ^ b;
      r.payload_byte = b;
      r.payload_valid = 1'b1;
    end
    if (last) begin
      n = sh_pos + 1;
      words = sh_count + 1;
      r.area_done = 1'b1;
      if (sh_pos >= PosMax || n < 2 || n[0]) begin
        r.status = StSize;
      end else if (sh_padding) begin
        r.status = StPadding;
      end else if (!sh_header_ok) begin
        r.status = StNibble;
      end else if (words * 2 != n || words * 2 < 4 || words > MaxAreaWords) begin
        r.status = StLength;
      end else if (sh_parity != b) begin
        r.status = StParity;
      end else begin
        r.status = StOk;
      end
      sh_pos = '0;
      sh_high = '0;
      sh_count = '0;
      sh_parity = sh_seed;
      sh_header_ok = 1'b0;
      sh_padding = 1'b0;
    end else if (sh_pos < PosMax) begin
      sh_pos = sh_pos + PosWidth'(1);
    end
    deframer_outputs.insert(deframer_outputs.size(), r);
  endtask

  always @(posedge clk) begin
    edad_result_t r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframer_outputs.size() == 0) begin
          report_mismatch("output transaction with nothing expected");
        end else begin
          r = deframer_outputs.pop_front();
          outputs_checked++;
          if (payload_byte !== r.payload_byte) begin
            report_mismatch($sformatf("payload_byte %h, expected %h", payload_byte,
                                      r.payload_byte));
          end
          if (payload_valid !== r.payload_valid) begin
            report_mismatch($sformatf("payload_valid %b, expected %b", payload_valid,
                                      r.payload_valid));
          end
          if (area_done !== r.area_done) begin
            report_mismatch($sformatf("area_done %b, expected %b", area_done, r.area_done));
          end
          if (status !== r.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
          end
          if (r.area_done) begin
            areas_by_status[r.status]++;
          end
        end
      end
      out_ready <= rx_stalls ? ($urandom_range(0, 99) >= 36) : 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (tx_gaps && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    area_byte <= b;
    is_last <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    deframe_byte(b, last);
    bytes_sent++;
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (deframer_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [7:0] value);
    drain_outputs();
    seed_we <= 1'b1;
    seed_data <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    sh_seed = value;
    seed_writes++;
  endtask

  function automatic logic [3:0] good_check(input logic [CountWidth-1:0] count);
    return CheckTarget ^ count[11:8] ^ count[7:4] ^ count[3:0];
  endfunction

  // fill < 0 gives random payload, otherwise every payload byte is fill.
  task automatic send_area(input int unsigned nbytes, input logic [CountWidth-1:0] count,
                           input logic [3:0] chk, input bit spoil_parity, input int fill);
    logic [7:0] parity;
    logic [7:0] b;
    int unsigned i;
    parity = sh_seed;
    for (i = 0; i < nbytes; i++) begin
      if (i == 0) begin
        b = {chk, count[11:8]};
      end else if (i == 1) begin
        b = count[7:0];
      end else if (i == nbytes - 1) begin
        b = parity ^ (spoil_parity ? 8'($urandom_range(1, 255)) : 8'h00);
      end else begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
        parity = parity ^ b;
      end
      send_byte(b, i == nbytes - 1);
    end
  endtask

  task automatic send_good_area(input int unsigned words, input int fill);
    send_area(words * 2, CountWidth'(words - 1), good_check(CountWidth'(words - 1)), 1'b0,
              fill);
  endtask

  task automatic test_header_cases();
    send_byte(8'($urandom), 1'b1);
    send_area(2, 12'h000, 4'h0, 1'b0, -1);
    send_area(4, 12'h000, 4'h0, 1'b0, -1);
    send_area(2, 12'h000, good_check(12'h000), 1'b0, -1);
    send_good_area(2, 8'h00);
    send_good_area(3, 8'hFF);
    send_area(4, 12'h001, good_check(12'h001) ^ 4'h8, 1'b0, -1);
    send_area(3, 12'h001, good_check(12'h001), 1'b0, -1);
  endtask

  task automatic test_status_codes();
    send_area(4, 12'h001, good_check(12'h001), 1'b1, -1);
    send_area(6, 12'h001, good_check(12'h001), 1'b0, -1);
    send_area(5, 12'h002, good_check(12'h002), 1'b0, 8'hA5);
  endtask

  task automatic test_parity_seed();
    write_seed(8'h00);
    send_area(4, 12'h001, good_check(12'h001), 1'b0, 8'h00);
    send_area(4, 12'h001, good_check(12'h001), 1'b1, 8'h00);
    write_seed(8'hFF);
    send_good_area(2, 8'hFF);
    send_good_area(4, -1);
    // The seed is taken when the second header byte arrives.
    write_seed(8'h3C);
    send_byte({good_check(12'h001), 4'h0}, 1'b0);
    write_seed(8'h5A);
    send_byte(8'h01, 1'b0);
    write_seed(8'hC3);
    send_byte(8'h12, 1'b0);
    send_byte(8'h5A ^ 8'h12, 1'b1);
  endtask

  task automatic test_random_areas();
    int unsigned start;
    int unsigned areas;
    int unsigned words;
    int unsigned kind;
    int unsigned i;
    int unsigned len;
    logic [CountWidth-1:0] count;
    start = bytes_sent;
    areas = 0;
    while (bytes_sent - start < RandomItems) begin
      tx_gaps = !(bytes_sent - start >= 250 && bytes_sent - start < 400);
      rx_stalls = tx_gaps;
      if (areas % 40 == 39) begin
        write_seed(8'($urandom));
      end
      words = ($urandom_range(0, 99) < 5) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      count = CountWidth'(words - 1);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_good_area(words, -1);
      end else if (kind < 65) begin
        send_area(words * 2, count, good_check(count), 1'b1, -1);
      end else if (kind < 73) begin
        send_area(words * 2, count, good_check(count) ^ 4'($urandom_range(1, 15)), 1'b0,
                  -1);
      end else if (kind < 81) begin
        count = CountWidth'($urandom_range(0, 99));
        send_area(words * 2, count, good_check(count), 1'b0, -1);
      end else if (kind < 87) begin
        len = $urandom_range(0, 1) ? words * 2 + 1 : words * 2 - 1;
        send_area(len, count, good_check(count), 1'($urandom_range(0, 1)), -1);
      end else if (kind < 92) begin
        send_area(words * 2, 12'h000, 4'h0, 1'($urandom_range(0, 1)), -1);
      end else begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++) begin
          send_byte(8'($urandom), i == len - 1);
        end
      end
      areas++;
    end
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_cases();
    test_status_codes();
    test_parity_seed();
    write_seed(SeedReset);
    test_random_areas();
    drain_outputs();
    if (deframer_outputs.size() != 0) begin
      report_mismatch($sformatf("%0d outputs never arrived", deframer_outputs.size()));
    end
    $display("Sent %0d bytes, checked %0d outputs, %0d seed writes.", bytes_sent,
             outputs_checked, seed_writes);
    $display("Areas: ok %0d, padding %0d, size %0d, nibble %0d, length %0d, parity %0d.",
             areas_by_status[StOk], areas_by_status[StPadding], areas_by_status[StSize],
             areas_by_status[StNibble], areas_by_status[StLength],
             areas_by_status[StParity]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
